// ----- hw/rtl/tpe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle plane equation package
// Shared constants and the side payload type for the plane equation pipeline.
// ----------------------------------------------------------------------------
package tpe_pkg;

  localparam int unsigned CoordBitsDefault = 24;
  localparam int unsigned TagBits = 24;
  localparam int unsigned NormBits = 16;
  localparam int unsigned DBits = 25;
  // Edge and cross product widths after optional pre-shift (edges <= 31 bits).
  localparam int unsigned CrossBits = 63;
  localparam int unsigned MagBits = 62;
  localparam int unsigned NMag = 30;      // normalized magnitude width
  localparam int unsigned SumBits = 62;   // sum of three 30-bit squares
  localparam int unsigned LenBits = 31;
  localparam int unsigned QBits = 17;

  typedef struct packed {
    logic [TagBits-1:0] tag;
    logic               nz;
  } tpe_side_t;

endpackage

// ----- hw/rtl/tpe_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle input channel
// Valid/ready channel carrying one triangle per beat.
// ----------------------------------------------------------------------------
interface tpe_in_if #(
  parameter int unsigned COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic [23:0]                  tri_index;
  logic signed [COORD_BITS-1:0] ax, ay, az, bx, by_coord, bz, cx, cy, cz;

  modport source (output valid, tri_index, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
                  input ready);
  modport sink (input valid, tri_index, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
                output ready);
endinterface

// ----- hw/rtl/tpe_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plane output channel
// Valid/ready channel carrying one plane equation per beat.
// ----------------------------------------------------------------------------
interface tpe_out_if;
  logic               valid;
  logic               ready;
  logic [23:0]        tri_index_out;
  logic signed [15:0] plane_nx, plane_ny, plane_nz;
  logic signed [24:0] plane_d;
  logic               plane_valid;

  modport source (output valid, tri_index_out, plane_nx, plane_ny, plane_nz, plane_d,
                  plane_valid, input ready);
  modport sink (input valid, tri_index_out, plane_nx, plane_ny, plane_nz, plane_d,
                plane_valid, output ready);
endinterface

// ----- hw/rtl/tpe_sqrt_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root stage
// One registered step of a restoring integer square root, two result bits.
// ----------------------------------------------------------------------------
module tpe_sqrt_stage
  import tpe_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [SumBits-1:0] rem_i,
  input  logic [LenBits-1:0] root_i,
  output logic [SumBits-1:0] rem_o,
  output logic [LenBits-1:0] root_o
);
  localparam int unsigned B0 = 2 * (LenBits - 1 - 2 * STEP);
  localparam int unsigned B1 = B0 - 2;

  logic [SumBits+1:0] rem_a, rem_b, trial_a, trial_b;
  logic [LenBits-1:0] root_a, root_b;
  logic [SumBits-1:0] rem_d;
  logic [LenBits-1:0] root_d;

  always_comb begin
    rem_a = {2'b0, rem_i};
    trial_a = ({3'b0, root_i} << (B0 / 2 + 1)) | ((SumBits + 2)'(1) << B0);
    root_a = root_i;
    if (rem_a >= trial_a) begin
      rem_a = rem_a - trial_a;
      root_a = root_i | (LenBits'(1) << (B0 / 2));
    end
    rem_b = rem_a;
    trial_b = ({3'b0, root_a} << (B1 / 2 + 1)) | ((SumBits + 2)'(1) << B1);
    root_b = root_a;
    if (rem_b >= trial_b) begin
      rem_b = rem_b - trial_b;
      root_b = root_a | (LenBits'(1) << (B1 / 2));
    end
    rem_d = rem_b[SumBits-1:0];
    root_d = root_b;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      root_o <= root_d;
    end
  end
endmodule

// ----- hw/rtl/tpe_div_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider stage
// One registered restoring division step for three quotients sharing a divisor.
// ----------------------------------------------------------------------------
module tpe_div_stage
  import tpe_pkg::*;
#(
  parameter int unsigned BIT = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [LenBits+1:0]   div_i,
  input  logic [3*48-1:0]      rem_i,
  input  logic [3*QBits-1:0]   q_i,
  output logic [3*48-1:0]      rem_o,
  output logic [3*QBits-1:0]   q_o
);
  logic [3*48-1:0]    rem_d;
  logic [3*QBits-1:0] q_d;
  logic [47:0]        sh;

  always_comb begin
    rem_d = rem_i;
    q_d = q_i;
    sh = 48'(div_i) << BIT;
    for (int k = 0; k < 3; k++) begin
      if (rem_i[k*48 +: 48] >= sh) begin
        rem_d[k*48 +: 48] = rem_i[k*48 +: 48] - sh;
        q_d[k*QBits + BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      q_o <= q_d;
    end
  end
endmodule

// ----- hw/rtl/triangle_plane_equation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle plane equation
// Unit normal and plane offset of a triangle from its edge cross product.
//
// Triangles enter on in_ch (valid/ready) and plane equations leave on
// out_ch. One triangle can be accepted every cycle while the pipeline is not
// frozen. Each beat passes through a fixed pipeline: edges, cross product,
// magnitude and normalize shift, squares, a 16-stage square root (two root
// bits per stage), a 17-stage divider shared by the three components, and
// offset products and rounding. The pipeline advances as a whole; when the
// last stage holds a beat and the receiver holds ready low, the whole
// pipeline freezes and in_ch.ready falls, so nothing is lost or repeated.
// Degenerate triangles leave with plane_valid low and zero outputs.
// Reset clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module triangle_plane_equation
  import tpe_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  tpe_in_if.sink    in_ch,
  tpe_out_if.source out_ch
);
  localparam int unsigned Pre = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
  localparam int unsigned EB = COORD_BITS + 1 - Pre;
  localparam int unsigned NSqrt = 16;
  localparam int unsigned NDiv = QBits;
  localparam int unsigned Depth = 45;
  localparam int unsigned NzStage = 7;

  logic en;
  logic [Depth-1:0] vld_q;
  assign en = !vld_q[Depth-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_ch.valid};
    end
  end

  // Vertex a and side info delay line to the offset stages.
  localparam int unsigned ALen = 43;
  localparam int unsigned SLen = 40;
  logic signed [COORD_BITS-1:0] a_q [ALen][3];
  tpe_side_t                    side_q [Depth];

  // Stage 1: edges.
  logic signed [EB-1:0] e1_q [3], e2_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_q[0] <= EB'(($signed({in_ch.bx[COORD_BITS-1], in_ch.bx}) -
                     $signed({in_ch.ax[COORD_BITS-1], in_ch.ax})) >>> Pre);
      e1_q[1] <= EB'(($signed({in_ch.by_coord[COORD_BITS-1], in_ch.by_coord}) -
                     $signed({in_ch.ay[COORD_BITS-1], in_ch.ay})) >>> Pre);
      e1_q[2] <= EB'(($signed({in_ch.bz[COORD_BITS-1], in_ch.bz}) -
                     $signed({in_ch.az[COORD_BITS-1], in_ch.az})) >>> Pre);
      e2_q[0] <= EB'(($signed({in_ch.cx[COORD_BITS-1], in_ch.cx}) -
                     $signed({in_ch.ax[COORD_BITS-1], in_ch.ax})) >>> Pre);
      e2_q[1] <= EB'(($signed({in_ch.cy[COORD_BITS-1], in_ch.cy}) -
                     $signed({in_ch.ay[COORD_BITS-1], in_ch.ay})) >>> Pre);
      e2_q[2] <= EB'(($signed({in_ch.cz[COORD_BITS-1], in_ch.cz}) -
                     $signed({in_ch.az[COORD_BITS-1], in_ch.az})) >>> Pre);
      a_q[0][0] <= in_ch.ax;
      a_q[0][1] <= in_ch.ay;
      a_q[0][2] <= in_ch.az;
      for (int i = 1; i < ALen; i++) a_q[i] <= a_q[i-1];
    end
  end

  // Stage 2: six products. Stage 3: differences.
  logic signed [2*EB-1:0] p_q [6];
  logic signed [CrossBits-1:0] cr_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= e1_q[1] * e2_q[2];
      p_q[1] <= e1_q[2] * e2_q[1];
      p_q[2] <= e1_q[2] * e2_q[0];
      p_q[3] <= e1_q[0] * e2_q[2];
      p_q[4] <= e1_q[0] * e2_q[1];
      p_q[5] <= e1_q[1] * e2_q[0];
      for (int k = 0; k < 3; k++) begin
        cr_q[k] <= CrossBits'(p_q[2*k]) - CrossBits'(p_q[2*k+1]);
      end
    end
  end

  // Stage 4: magnitudes. Stage 5: max. Stage 6: leading one position.
  logic [MagBits-1:0] mag_q [3], mx_c, mag4_q [3];
  logic [2:0]         sgn_q [SLen];
  logic [MagBits-1:0] mx_q;
  logic [5:0]         lz_c, lz_q;
  always_comb begin
    mx_c = mag_q[0];
    if (mag_q[1] > mx_c) mx_c = mag_q[1];
    if (mag_q[2] > mx_c) mx_c = mag_q[2];
  end
  always_comb begin
    lz_c = '0;
    for (int b = 0; b < MagBits; b++) begin
      if (mx_q[b]) lz_c = 6'(b);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mag_q[k] <= cr_q[k][CrossBits-1] ? MagBits'(-cr_q[k]) : MagBits'(cr_q[k]);
      end
      mx_q <= mx_c;
      mag4_q <= mag_q;
      lz_q <= lz_c;
    end
  end

  // Stage 7: shift to [2^29, 2^30). Stage 8: squares. Stage 9: sum.
  logic [NMag-1:0]    nm_q [3];
  logic               nz6_q;
  logic [MagBits-1:0] mag5_q [3];
  logic [MagBits-1:0] mx5_q;
  logic [2*NMag-1:0]  sq_q [3];
  logic [NMag-1:0]    nm7_q [3];
  logic [SumBits-1:0] sum_q;
  logic [NMag-1:0]    nm8_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      mag5_q <= mag4_q;
      mx5_q <= mx_q;
      nz6_q <= (mx5_q != '0);
      for (int k = 0; k < 3; k++) begin
        if (lz_q >= 6'd29) nm_q[k] <= NMag'(mag5_q[k] >> (lz_q - 6'd29));
        else nm_q[k] <= NMag'(mag5_q[k] << (6'd29 - lz_q));
        sq_q[k] <= nm_q[k] * nm_q[k];
      end
      nm7_q <= nm_q;
      sum_q <= SumBits'(sq_q[0]) + SumBits'(sq_q[1]) + SumBits'(sq_q[2]);
      nm8_q <= nm7_q;
    end
  end

  // Stages 10..25: square root.
  logic [SumBits-1:0] srem [NSqrt+1];
  logic [LenBits-1:0] sroot [NSqrt+1];
  logic [NMag-1:0]    snm_q [NSqrt][3];
  assign srem[0] = sum_q;
  assign sroot[0] = '0;
  for (genvar s = 0; s < NSqrt; s++) begin : g_sqrt
    tpe_sqrt_stage #(.STEP(s)) u_sqrt (
      .clk_i, .en_i(en), .rem_i(srem[s]), .root_i(sroot[s]),
      .rem_o(srem[s+1]), .root_o(sroot[s+1])
    );
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      snm_q[0] <= nm8_q;
      for (int i = 1; i < NSqrt; i++) snm_q[i] <= snm_q[i-1];
    end
  end

  // Stage 26: dividends (mag<<16)+len, divisor 2*len. Stages 27..43: divide.
  logic [LenBits+1:0]   dv_q [NDiv];
  logic [3*48-1:0]      drem [NDiv+1];
  logic [3*QBits-1:0]   dq [NDiv+1];
  logic [3*48-1:0]      num_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        num_q[k*48 +: 48] <= {2'b0, snm_q[NSqrt-1][k], 16'b0} + 48'(sroot[NSqrt]);
      end
      dv_q[0] <= {sroot[NSqrt], 1'b0} & {(LenBits+2){1'b1}};
      for (int j = 1; j < NDiv; j++) dv_q[j] <= dv_q[j-1];
    end
  end
  assign drem[0] = num_q;
  assign dq[0] = '0;
  for (genvar j = 0; j < NDiv; j++) begin : g_div
    tpe_div_stage #(.BIT(NDiv - 1 - j)) u_div (
      .clk_i, .en_i(en), .div_i(dv_q[j]), .rem_i(drem[j]), .q_i(dq[j]),
      .rem_o(drem[j+1]), .q_o(dq[j+1])
    );
  end

  // Sign/side delay lines.
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= {in_ch.tri_index, 1'b0};
      for (int i = 1; i < Depth; i++) begin
        if (i == NzStage) side_q[i] <= {side_q[i-1].tag, nz6_q};
        else side_q[i] <= side_q[i-1];
      end
      sgn_q[0] <= {cr_q[2][CrossBits-1], cr_q[1][CrossBits-1], cr_q[0][CrossBits-1]};
      for (int i = 1; i < SLen; i++) sgn_q[i] <= sgn_q[i-1];
    end
  end

  // Stage 44: saturate, sign, products. Stage 45: sum, round, clamp.
  logic signed [NormBits-1:0] n_q [3], n2_q [3];
  logic signed [COORD_BITS+NormBits-1:0] ap_q [3];
  logic signed [DBits-1:0] d_q;
  logic signed [COORD_BITS+NormBits+1:0] t_c, r_c;
  logic [QBits-1:0] qv;
  logic signed [NormBits-1:0] n_c [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qv = dq[NDiv][k*QBits +: QBits];
      if (qv > QBits'(32767)) qv = QBits'(32767);
      n_c[k] = sgn_q[SLen-1][k] ? -$signed(NormBits'(qv)) : $signed(NormBits'(qv));
    end
    t_c = -((COORD_BITS+NormBits+2)'(ap_q[0]) + (COORD_BITS+NormBits+2)'(ap_q[1]) +
            (COORD_BITS+NormBits+2)'(ap_q[2]));
    if (t_c >= 0) r_c = (t_c + (1 <<< 14)) >>> 15;
    else r_c = -((-t_c + (1 <<< 14)) >>> 15);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        n_q[k] <= n_c[k];
        ap_q[k] <= a_q[ALen-1][k] * n_c[k];
      end
      n2_q <= n_q;
      if (r_c > 16777215) d_q <= DBits'(16777215);
      else if (r_c < -16777216) d_q <= DBits'(-16777216);
      else d_q <= DBits'(r_c);
    end
  end

  logic nzf;
  assign nzf = side_q[Depth-1].nz;
  assign out_ch.valid = vld_q[Depth-1];
  assign out_ch.tri_index_out = side_q[Depth-1].tag;
  assign out_ch.plane_nx = nzf ? n2_q[0] : '0;
  assign out_ch.plane_ny = nzf ? n2_q[1] : '0;
  assign out_ch.plane_nz = nzf ? n2_q[2] : '0;
  assign out_ch.plane_d = nzf ? d_q : '0;
  assign out_ch.plane_valid = nzf;
endmodule

// ----- tb/tb_plane_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plane equation checker
// Watches the triangle and plane channels, computes the expected unit
// normal and offset of each accepted triangle, and compares every plane
// beat field by field with the oldest expected plane.
// ----------------------------------------------------------------------------
module tb_plane_checker #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  tpe_in_if  in_ch,
  tpe_out_if out_ch,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned planes_o,
  output int unsigned degenerate_o
);

  typedef struct packed {
    logic [23:0]        tag;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [24:0] d;
    logic               ok;
  } plane_t;

  plane_t planes_q[$];

  function automatic longint signed floor_shr(longint signed v, int s);
    if (s <= 0) begin
      return v;
    end
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned num);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > num) bitv >>= 2;
    while (bitv != 0) begin
      if (num >= root + bitv) begin
        num -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic plane_t plane_of(logic [23:0] tag,
                                      logic signed [COORD_BITS-1:0] v[9]);
    longint signed a[3], e1[3], e2[3], cr[3], nrm[3], dot, t, d;
    longint unsigned mag[3], m, sum, len, q;
    int rs, ls, pre;
    plane_t p;
    pre = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
    rs = 0;
    ls = 0;
    p = '0;
    p.tag = tag;
    for (int i = 0; i < 3; i++) begin
      a[i] = v[i];
      e1[i] = floor_shr(longint'(v[3 + i]) - a[i], pre);
      e2[i] = floor_shr(longint'(v[6 + i]) - a[i], pre);
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    m = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (cr[i] < 0) ? longint'(-cr[i]) : cr[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      return p;
    end
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      rs++;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      ls++;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (mag[i] >> rs) << ls;
      sum += mag[i] * mag[i];
    end
    len = int_sqrt(sum);
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 16) + len) / (2 * len);
      if (q > 32767) q = 32767;
      nrm[i] = (cr[i] < 0) ? -longint'(q) : longint'(q);
      dot += a[i] * nrm[i];
    end
    t = -dot;
    d = (t >= 0) ? ((t + (1 << 14)) >>> 15) : -((-t + (1 << 14)) >>> 15);
    if (d > 16777215) d = 16777215;
    if (d < -16777216) d = -16777216;
    p.nx = nrm[0][15:0];
    p.ny = nrm[1][15:0];
    p.nz = nrm[2][15:0];
    p.d = d[24:0];
    p.ok = 1'b1;
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    plane_t exp_p, act_p;
    logic signed [COORD_BITS-1:0] v[9];
    if (!rst_ni) begin
      fail_cnt_o <= 0;
      pending_o <= 0;
      planes_o <= 0;
      degenerate_o <= 0;
      planes_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        v = '{in_ch.ax, in_ch.ay, in_ch.az, in_ch.bx, in_ch.by_coord, in_ch.bz,
              in_ch.cx, in_ch.cy, in_ch.cz};
        planes_q.push_back(plane_of(in_ch.tri_index, v));
      end
      if (out_ch.valid && out_ch.ready) begin
        act_p = '{out_ch.tri_index_out, out_ch.plane_nx, out_ch.plane_ny,
                  out_ch.plane_nz, out_ch.plane_d, out_ch.plane_valid};
        planes_o <= planes_o + 1;
        if (!out_ch.plane_valid) degenerate_o <= degenerate_o + 1;
        if (planes_q.size() == 0) begin
          $display("%t: unexpected plane beat %h", $time, act_p);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_p = planes_q.pop_front();
          if (exp_p.tag !== act_p.tag || exp_p.nx !== act_p.nx ||
              exp_p.ny !== act_p.ny || exp_p.nz !== act_p.nz ||
              exp_p.d !== act_p.d || exp_p.ok !== act_p.ok) begin
            $display("%t: plane mismatch, expected tag %h n %0d %0d %0d d %0d ok %b",
                     $time, exp_p.tag, exp_p.nx, exp_p.ny, exp_p.nz, exp_p.d, exp_p.ok);
            $display("%t:                 actual tag %h n %0d %0d %0d d %0d ok %b",
                     $time, act_p.tag, act_p.nx, act_p.ny, act_p.nz, act_p.d, act_p.ok);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      pending_o <= unsigned'(planes_q.size());
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle plane equation testbench
// Drives directed and random triangles with random idle cycles on both
// channels, a long receiver hold-off and a drain pause, and reports the
// verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_top;
  import tpe_pkg::*;

  localparam int unsigned CB = CoordBitsDefault;
  localparam int unsigned NumRandom = 900;

  logic clk_i;
  logic rst_ni;
  int unsigned fail_cnt, pending, planes, degenerate;
  bit hold_on;
  bit quiet_sink;
  bit sink_stall_done;

  tpe_in_if #(.COORD_BITS(CB)) in_ch ();
  tpe_out_if out_ch ();

  triangle_plane_equation #(.COORD_BITS(CB)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  tb_plane_checker #(.COORD_BITS(CB)) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .planes_o    (planes),
    .degenerate_o(degenerate)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic logic [CB-1:0] rand_coord(int mode);
    case (mode)
      0: return CB'($urandom());
      1: return CB'($urandom_range(0, 63)) - CB'(32);
      2: return $urandom_range(0, 1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
      default: return CB'(signed'($urandom_range(0, 8191))) - CB'(4096);
    endcase
  endfunction

  task automatic send(logic [23:0] tag, logic [CB-1:0] v[9], bit may_idle);
    while (may_idle && !quiet_sink && $urandom_range(0, 99) < 24) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.tri_index <= tag;
    {in_ch.ax, in_ch.ay, in_ch.az} <= {v[0], v[1], v[2]};
    {in_ch.bx, in_ch.by_coord, in_ch.bz} <= {v[3], v[4], v[5]};
    {in_ch.cx, in_ch.cy, in_ch.cz} <= {v[6], v[7], v[8]};
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Receiver: random stalls, one quiet stretch, and one long hold-off.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_on && !sink_stall_done) begin
        out_ch.ready <= 1'b0;
        repeat (120) @(posedge clk_i);
        sink_stall_done = 1'b1;
      end
      out_ch.ready <= quiet_sink ? 1'b1 : ($urandom_range(0, 99) >= 24);
    end
  end

  initial begin
    logic [CB-1:0] v[9];
    int mode;
    in_ch.valid = 1'b0;
    in_ch.tri_index = '0;
    {in_ch.ax, in_ch.ay, in_ch.az, in_ch.bx, in_ch.by_coord, in_ch.bz} = '0;
    {in_ch.cx, in_ch.cy, in_ch.cz} = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all-zero and collinear triangles, axis-aligned faces,
    // full-scale coordinates, extreme offsets and full-scale normals.
    v = '{default: '0};
    send(24'h000000, v, 1'b0);
    v = '{CB'(100), CB'(200), CB'(300), CB'(200), CB'(400), CB'(600),
          CB'(300), CB'(600), CB'(900)};
    send(24'hFFFFFF, v, 1'b0);
    v = '{CB'(0), CB'(0), CB'(4096), CB'(4096), CB'(0), CB'(4096),
          CB'(0), CB'(4096), CB'(4096)};
    send(24'h000001, v, 1'b0);
    v = '{CB'(4096), CB'(0), CB'(0), CB'(4096), CB'(0), CB'(4096),
          CB'(4096), CB'(4096), CB'(0)};
    send(24'h800000, v, 1'b0);
    v = '{default: {1'b0, {(CB-1){1'b1}}}};
    v[3] = {1'b1, {(CB-1){1'b0}}};
    v[7] = {1'b1, {(CB-1){1'b0}}};
    send(24'h555555, v, 1'b0);
    v = '{default: {1'b1, {(CB-1){1'b0}}}};
    v[3] = {1'b0, {(CB-1){1'b1}}};
    v[7] = {1'b0, {(CB-1){1'b1}}};
    send(24'hAAAAAA, v, 1'b0);
    v = '{CB'(-8388608), CB'(-8388608), CB'(-8388608), CB'(8388607), CB'(-8388608),
          CB'(-8388608), CB'(-8388608), CB'(8388607), CB'(-8388608)};
    send(24'h123456, v, 1'b0);
    v = '{CB'(0), CB'(0), CB'(0), CB'(1), CB'(0), CB'(0), CB'(0), CB'(1), CB'(0)};
    send(24'h654321, v, 1'b0);
    v = '{CB'(5), CB'(-7), CB'(9), CB'(5), CB'(-7), CB'(9), CB'(1), CB'(2), CB'(3)};
    send(24'h0F0F0F, v, 1'b0);
    for (int i = 0; i < 10; i++) begin
      for (int k = 0; k < 9; k++) v[k] = rand_coord(2);
      send(24'($urandom()), v, 1'b0);
    end

    // Random: mostly proper triangles with mixed magnitudes, some degenerate.
    for (int n = 0; n < NumRandom; n++) begin
      if (n == 300) begin
        hold_on = 1'b1;
      end
      if (n == 500) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      quiet_sink = (n >= 600 && n < 700);
      mode = $urandom_range(0, 3);
      for (int k = 0; k < 9; k++) v[k] = rand_coord(mode);
      if ($urandom_range(0, 19) == 0) begin
        for (int k = 6; k < 9; k++) v[k] = v[k - 3];
      end
      send(24'($urandom()), v, 1'b1);
    end
    in_ch.valid <= 1'b0;
    @(posedge clk_i);

    for (int w = 0; pending != 0 && w < 20000; w++) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Covered %0d plane beats, %0d of them degenerate, with stalls on both sides.",
             planes, degenerate);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
